// File: hw/rtl/ps2_mouse_cursor_tracker_defines.svh
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker assertion macros
// Checks are sampled on the rising edge of clock and held off during reset.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_CURSOR_TRACKER_DEFINES_SVH
`define PS2_MOUSE_CURSOR_TRACKER_DEFINES_SVH

// condition holds at every edge outside reset
`define PMCT_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("pmct assertion failed");

// consequent holds in the cycle after the antecedent
`define PMCT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pmct assertion failed");

`endif

// File: hw/rtl/pmct_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Shared widths, types, register indexes and reset values.
// ----------------------------------------------------------------------------
package pmct_pkg;

   localparam int COORD_W     = 10;
   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 2;

   typedef logic [COORD_W-1:0]     coord_type;
   typedef logic [BYTE_W-1:0]      byte_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   // register indexes
   localparam csr_index_type CSR_X_LIMIT = 2'd0;
   localparam csr_index_type CSR_Y_LIMIT = 2'd1;

   // header byte bits
   localparam int HDR_SYNC_BIT  = 3;
   localparam int HDR_LEFT_BIT  = 0;
   localparam int HDR_RIGHT_BIT = 1;

   localparam coord_type X_LIMIT_RESET = 10'd319;
   localparam coord_type Y_LIMIT_RESET = 10'd239;
   localparam coord_type POS_X_RESET   = 10'd160;
   localparam coord_type POS_Y_RESET   = 10'd120;

endpackage

// File: hw/rtl/pmct_axis_sat.sv
// ----------------------------------------------------------------------------
// Cursor axis update
// Applies a signed 8-bit delta to one coordinate and clamps to 0..limit.
// ----------------------------------------------------------------------------
module pmct_axis_sat (
   input  pmct_pkg::coord_type pos,
   input  pmct_pkg::byte_type  delta,
   input  logic                subtract,
   input  pmct_pkg::coord_type limit,
   output pmct_pkg::coord_type pos_new
);

   logic signed [pmct_pkg::COORD_W+1:0] pos_ext;
   logic signed [pmct_pkg::COORD_W+1:0] delta_ext;
   logic signed [pmct_pkg::COORD_W+1:0] sum;

   assign pos_ext   = {2'b00, pos};
   assign delta_ext = {{(pmct_pkg::COORD_W+2-pmct_pkg::BYTE_W){delta[pmct_pkg::BYTE_W-1]}},
                       delta};
   assign sum       = subtract ? (pos_ext - delta_ext) : (pos_ext + delta_ext);

   always_comb begin
      if (sum[pmct_pkg::COORD_W+1]) begin
         pos_new = '0;
      end else if (sum[pmct_pkg::COORD_W:0] > {1'b0, limit}) begin
         pos_new = limit;
      end else begin
         pos_new = sum[pmct_pkg::COORD_W-1:0];
      end
   end

endmodule

// File: hw/rtl/ps2_mouse_cursor_tracker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker
// A result is presented in the cycle after the third packet byte's transfer.
// Throughput: one byte per cycle unless a held result stalls; the output register frees itself
// in the cycle its result is taken, so bytes keep flowing while a result is handed over.
// Reset (synchronous): packet sync cleared, cursor at 160,120, limits 319 and 239.
// ----------------------------------------------------------------------------
`include "ps2_mouse_cursor_tracker_defines.svh"

module ps2_mouse_cursor_tracker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pmct_pkg::byte_type        req_data_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pmct_pkg::coord_type       rsp_cursor_x,
   output pmct_pkg::coord_type       rsp_cursor_y,
   output logic                      rsp_left_pressed,
   output logic                      rsp_right_pressed,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  pmct_pkg::csr_index_type   csr_index,
   input  pmct_pkg::coord_type       csr_data
);

   typedef enum logic [1:0] {
      BP_HEADER,
      BP_DX,
      BP_DY
   } byte_pos_type;

   byte_pos_type        byte_pos_ff, byte_pos_in;
   pmct_pkg::byte_type  header_ff, header_in;
   pmct_pkg::byte_type  dx_ff, dx_in;
   pmct_pkg::coord_type pos_x_ff, pos_x_in;
   pmct_pkg::coord_type pos_y_ff, pos_y_in;
   pmct_pkg::coord_type x_limit_ff, x_limit_in;
   pmct_pkg::coord_type y_limit_ff, y_limit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pmct_pkg::coord_type rsp_x_ff;
   pmct_pkg::coord_type rsp_y_ff;
   logic                rsp_left_ff;
   logic                rsp_right_ff;

   logic                req_xfer;
   logic                packet_done;
   pmct_pkg::coord_type x_new;
   pmct_pkg::coord_type y_new;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   pmct_axis_sat u_sat_x (
      .pos      (pos_x_ff),
      .delta    (dx_ff),
      .subtract (1'b0),
      .limit    (x_limit_ff),
      .pos_new  (x_new)
   );

   // up reduces y
   pmct_axis_sat u_sat_y (
      .pos      (pos_y_ff),
      .delta    (req_data_byte),
      .subtract (1'b1),
      .limit    (y_limit_ff),
      .pos_new  (y_new)
   );

   always_comb begin
      byte_pos_in  = byte_pos_ff;
      header_in    = header_ff;
      dx_in        = dx_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      packet_done  = 1'b0;
      if (req_xfer) begin
         unique case (byte_pos_ff)
            BP_DX: begin
               dx_in       = req_data_byte;
               byte_pos_in = BP_DY;
            end
            BP_DY: begin
               pos_x_in    = x_new;
               pos_y_in    = y_new;
               packet_done = 1'b1;
               byte_pos_in = BP_HEADER;
            end
            default: begin
               // header slot, also taken for the unused position code
               if (req_data_byte[pmct_pkg::HDR_SYNC_BIT]) begin
                  header_in   = req_data_byte;
                  byte_pos_in = BP_DX;
               end else begin
                  byte_pos_in = BP_HEADER;
               end
            end
         endcase
      end
      rsp_valid_in = packet_done || (rsp_valid_ff && !rsp_ready);
   end

   always_comb begin
      x_limit_in = x_limit_ff;
      y_limit_in = y_limit_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pmct_pkg::CSR_X_LIMIT: x_limit_in = csr_data;
            pmct_pkg::CSR_Y_LIMIT: y_limit_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff  <= BP_HEADER;
         header_ff    <= '0;
         dx_ff        <= '0;
         pos_x_ff     <= pmct_pkg::POS_X_RESET;
         pos_y_ff     <= pmct_pkg::POS_Y_RESET;
         x_limit_ff   <= pmct_pkg::X_LIMIT_RESET;
         y_limit_ff   <= pmct_pkg::Y_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         byte_pos_ff  <= byte_pos_in;
         header_ff    <= header_in;
         dx_ff        <= dx_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         x_limit_ff   <= x_limit_in;
         y_limit_ff   <= y_limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (packet_done) begin
         rsp_x_ff     <= x_new;
         rsp_y_ff     <= y_new;
         rsp_left_ff  <= header_ff[pmct_pkg::HDR_LEFT_BIT];
         rsp_right_ff <= header_ff[pmct_pkg::HDR_RIGHT_BIT];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_x      = rsp_x_ff;
   assign rsp_cursor_y      = rsp_y_ff;
   assign rsp_left_pressed  = rsp_left_ff;
   assign rsp_right_pressed = rsp_right_ff;

   // a pending result always mirrors the tracked position
   `PMCT_ASSERT_ALWAYS(a_rsp_tracks_pos,
      !rsp_valid_ff || (rsp_x_ff == pos_x_ff && rsp_y_ff == pos_y_ff))
   // a stored header always carried the sync bit
   `PMCT_ASSERT_ALWAYS(a_header_synced,
      byte_pos_ff != BP_DX || header_ff[pmct_pkg::HDR_SYNC_BIT])
   // third byte transfer produces a result
   `PMCT_ASSERT_NEXT(a_third_byte_result,
      req_xfer && byte_pos_ff == BP_DY, rsp_valid_ff)
   // other bytes never invent a result
   `PMCT_ASSERT_NEXT(a_no_spurious_result,
      !rsp_valid_ff && !(req_xfer && byte_pos_ff == BP_DY), !rsp_valid_ff)

endmodule

// File: sim/ps2_mouse_cursor_tracker_test.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker testbench
// Feeds mouse bytes over the request channel and predicts the cursor position
// and button state of each completed packet. Covers bad header bytes, broken
// packets, saturation at both edges and limit register writes. Both channels
// stall at random, and every result is checked in order as it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ps2_mouse_cursor_tracker_test;

   localparam int STALL_LIMIT     = 1000;
   localparam int SETTLE_CYCLES   = 4;
   localparam int RANDOM_PHASES   = 6;
   localparam int BYTES_PER_PHASE = 175;

   // indexes that decode to no register
   localparam pmct_pkg::csr_index_type CSR_SPARE_A = 2'd2;
   localparam pmct_pkg::csr_index_type CSR_SPARE_B = 2'd3;

   typedef enum logic [1:0] {SLOT_HEADER, SLOT_DX, SLOT_DY} packet_slot_type;

   typedef struct packed {
      pmct_pkg::coord_type x;
      pmct_pkg::coord_type y;
      logic                left;
      logic                right;
   } cursor_report_type;

   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    req_valid     = 1'b0;
   logic                    req_ready;
   pmct_pkg::byte_type      req_data_byte = '0;
   logic                    rsp_valid;
   logic                    rsp_ready     = 1'b0;
   pmct_pkg::coord_type     rsp_cursor_x;
   pmct_pkg::coord_type     rsp_cursor_y;
   logic                    rsp_left_pressed;
   logic                    rsp_right_pressed;
   logic                    csr_valid     = 1'b0;
   logic                    csr_ready;
   pmct_pkg::csr_index_type csr_index     = '0;
   pmct_pkg::coord_type     csr_data      = '0;

   // cursor tracking model
   packet_slot_type     slot;
   pmct_pkg::byte_type  header_seen;
   pmct_pkg::byte_type  dx_seen;
   pmct_pkg::coord_type cursor_x_now;
   pmct_pkg::coord_type cursor_y_now;
   pmct_pkg::coord_type x_limit_now;
   pmct_pkg::coord_type y_limit_now;
   cursor_report_type   pending_reports[$];

   int  mismatch_count = 0;
   int  bytes_sent     = 0;
   int  stall_cycles   = 0;
   bit  req_gaps_on    = 1'b1;
   bit  rsp_gaps_on    = 1'b1;

   ps2_mouse_cursor_tracker i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cursor_x      (rsp_cursor_x),
      .rsp_cursor_y      (rsp_cursor_y),
      .rsp_left_pressed  (rsp_left_pressed),
      .rsp_right_pressed (rsp_right_pressed),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic pmct_pkg::coord_type clamp_coord(input int value,
                                                       input pmct_pkg::coord_type hi);
      if (value < 0)
         return '0;
      if (value > int'(hi))
         return hi;
      return pmct_pkg::coord_type'(value);
   endfunction

   task automatic track_byte(input pmct_pkg::byte_type value);
      cursor_report_type report;
      case (slot)
         SLOT_DX: begin
            dx_seen = value;
            slot    = SLOT_DY;
         end
         SLOT_DY: begin
            slot         = SLOT_HEADER;
            cursor_x_now = clamp_coord(int'(cursor_x_now) + int'($signed(dx_seen)),
                                       x_limit_now);
            // up is positive dy, screen y grows downward
            cursor_y_now = clamp_coord(int'(cursor_y_now) - int'($signed(value)),
                                       y_limit_now);
            report.x     = cursor_x_now;
            report.y     = cursor_y_now;
            report.left  = header_seen[pmct_pkg::HDR_LEFT_BIT];
            report.right = header_seen[pmct_pkg::HDR_RIGHT_BIT];
            pending_reports.push_back(report);
         end
         default: begin
            if (value[pmct_pkg::HDR_SYNC_BIT]) begin
               header_seen = value;
               slot        = SLOT_DX;
            end else begin
               slot = SLOT_HEADER;
            end
         end
      endcase
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // samples every transfer; results are checked before the model advances
   always @(posedge clock) begin
      cursor_report_type want;
      if (reset) begin
         slot         = SLOT_HEADER;
         header_seen  = '0;
         dx_seen      = '0;
         cursor_x_now = pmct_pkg::POS_X_RESET;
         cursor_y_now = pmct_pkg::POS_Y_RESET;
         x_limit_now  = pmct_pkg::X_LIMIT_RESET;
         y_limit_now  = pmct_pkg::Y_LIMIT_RESET;
         pending_reports.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual x %0d y %0d left %0b right %0b",
                        $time, rsp_cursor_x, rsp_cursor_y, rsp_left_pressed,
                        rsp_right_pressed);
               mismatch_count++;
            end else begin
               want = pending_reports.pop_front();
               check_field("cursor_x", int'(want.x), int'(rsp_cursor_x));
               check_field("cursor_y", int'(want.y), int'(rsp_cursor_y));
               check_field("left_pressed", int'(want.left), int'(rsp_left_pressed));
               check_field("right_pressed", int'(want.right), int'(rsp_right_pressed));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pmct_pkg::CSR_X_LIMIT: x_limit_now = csr_data;
               pmct_pkg::CSR_Y_LIMIT: y_limit_now = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            track_byte(req_data_byte);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   // result receiver with random back-pressure
   initial begin
      int  gap;
      bit  taken;
      @(negedge clock);
      forever begin
         gap = rsp_gaps_on ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do begin
            @(posedge clock);
            taken = rsp_valid && rsp_ready;
            @(negedge clock);
         end while (!taken);
      end
   end

   task automatic send_byte(input pmct_pkg::byte_type value);
      int  gap;
      bit  taken;
      gap = req_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      do begin
         @(posedge clock);
         taken = req_ready;
         @(negedge clock);
      end while (!taken);
      bytes_sent++;
   endtask

   task automatic send_packet(input pmct_pkg::byte_type header, input pmct_pkg::byte_type dx,
                              input pmct_pkg::byte_type dy);
      send_byte(header);
      send_byte(dx);
      send_byte(dy);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (pending_reports.size() != 0);
   endtask

   // hold keeps valid high for a following write
   task automatic write_csr(input pmct_pkg::csr_index_type idx,
                            input pmct_pkg::coord_type value, input bit hold);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do begin
         @(posedge clock);
         taken = csr_ready;
         @(negedge clock);
      end while (!taken);
      if (!hold)
         csr_valid <= 1'b0;
   endtask

   task automatic set_limits(input pmct_pkg::coord_type x_lim,
                             input pmct_pkg::coord_type y_lim);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_csr(pmct_pkg::CSR_X_LIMIT, x_lim, 1'b1);
      write_csr(pmct_pkg::CSR_Y_LIMIT, y_lim, 1'b0);
   endtask

   task automatic test_packet_basics();
      send_packet(8'h08, 8'h7F, 8'h80);
      send_packet(8'h0B, 8'h80, 8'h7F);
      // headers without the sync bit are dropped
      send_byte(8'h00);
      send_byte(8'hF7);
      send_packet(8'hFF, 8'h00, 8'hFF);
   endtask

   task automatic test_limit_registers();
      set_limits(10'd1023, 10'd1023);
      send_packet(8'h09, 8'h7F, 8'h80);
      send_packet(8'h0A, 8'h7F, 8'h80);
      // limits lowered under the cursor only bite on the next packet
      set_limits(10'd5, 10'd3);
      @(negedge clock);
      write_csr(CSR_SPARE_A, 10'd0, 1'b1);
      write_csr(CSR_SPARE_B, 10'd1023, 1'b0);
      send_packet(8'h08, 8'h00, 8'h00);
      set_limits(10'd0, 10'd0);
      send_packet(8'h0C, 8'h7F, 8'h80);
   endtask

   task automatic test_random_traffic();
      pmct_pkg::coord_type x_lim;
      pmct_pkg::coord_type y_lim;
      int                  phase_end;
      int                  pick;
      pmct_pkg::byte_type  header;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               x_lim = pmct_pkg::X_LIMIT_RESET;
               y_lim = pmct_pkg::Y_LIMIT_RESET;
            end
            1: begin x_lim = 10'd1023;      y_lim = 10'd1023;      end
            2: begin x_lim = 10'd0;         y_lim = 10'd0;         end
            3: begin x_lim = 10'd1023;      y_lim = 10'd0;         end
            default: begin
               x_lim = pmct_pkg::coord_type'($urandom_range(0, 1023));
               y_lim = pmct_pkg::coord_type'($urandom_range(0, 1023));
            end
         endcase
         req_gaps_on = (phase != 2) && (phase != 4);
         rsp_gaps_on = (phase != 2) && (phase != 5);
         set_limits(x_lim, y_lim);
         if ($urandom_range(0, 1)) begin
            @(negedge clock);
            write_csr($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                      pmct_pkg::coord_type'($urandom_range(0, 1023)), 1'b0);
         end
         phase_end = bytes_sent + BYTES_PER_PHASE;
         while (bytes_sent < phase_end) begin
            pick   = $urandom_range(0, 99);
            header = pmct_pkg::byte_type'($urandom_range(0, 255)) |
                     (8'h01 << pmct_pkg::HDR_SYNC_BIT);
            if (pick < 78) begin
               send_packet(header, pmct_pkg::byte_type'($urandom_range(0, 255)),
                           pmct_pkg::byte_type'($urandom_range(0, 255)));
            end else if (pick < 86) begin
               send_byte(pmct_pkg::byte_type'($urandom_range(0, 255)));
            end else if (pick < 92) begin
               // packet cut short, next header lands as a delta
               send_byte(header);
               send_byte(pmct_pkg::byte_type'($urandom_range(0, 255)));
            end else if (pick < 95) begin
               wait_for_results();
            end else begin
               send_packet(header, $urandom_range(0, 1) ? 8'h7F : 8'h80,
                           $urandom_range(0, 1) ? 8'h7F : 8'h80);
            end
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_packet_basics();
      test_limit_registers();
      test_random_traffic();
      wait_for_results();
      repeat (8) @(negedge clock);
      if (pending_reports.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_reports.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/pmct_pkg.sv
hw/rtl/pmct_axis_sat.sv
hw/rtl/ps2_mouse_cursor_tracker.sv
sim/ps2_mouse_cursor_tracker_test.sv
